// ===== sv/pba_pkg.sv =====
// Shared constants, codes and helper functions for the page bitmap allocator.
package pba_pkg;

   // Defaults for the top-level parameters
   localparam int PAGE_TOTAL_DEFAULT      = 8192;
   localparam int PAGE_BYTES_LOG2_DEFAULT = 12;

   // Map word geometry: 64 page bits per memory word
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;

   // Field widths
   localparam int OPCODE_W     = 2;
   localparam int FREE_ADDR_W  = 32;
   localparam int STATUS_W     = 2;
   localparam int PAGE_ADDR_W  = 25;
   localparam int FIRST_W      = 13;
   localparam int COUNT_W      = 14;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 14;

   // Register reset values
   localparam logic [FIRST_W-1:0] FIRST_RESET = 13'd256;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd4096;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_FIRST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_COUNT = 2'd1;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_MAP = 2'd2;

   // Index of the lowest clear bit of a word that has at least one clear bit.
   // Binary search: six halving steps.
   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
      logic [WORD_BITS-1:0] v;
      logic [WORD_BITS-1:0] low_mask;
      logic [BIT_W-1:0]     idx;
      v   = ~word;
      idx = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         low_mask = (WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1);
         if ((v & low_mask) == '0) begin
            v   = v >> (1 << k);
            idx = idx | (BIT_W'(1) << k);
         end
      end
      return idx;
   endfunction

endpackage

// ===== sv/pba_word_ram.sv =====
// Single-port-write, single-port-read word memory with registered read data.
module pba_word_ram
   import pba_pkg::*;
#(
   parameter int DEPTH  = PAGE_TOTAL_DEFAULT / WORD_BITS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [ADDR_W-1:0]    write_address,
   input  logic [WORD_BITS-1:0] write_data,
   input  logic [ADDR_W-1:0]    read_address,
   output logic [WORD_BITS-1:0] read_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] read_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== sv/page_bitmap_allocator_core.sv =====
// Page bitmap allocator: used-bit map in 64-bit words, word-serial first-free scan.
// Alloc: one-word-per-cycle scan through the map memory read port (WORDS = PAGE_TOTAL/64,
//   128 by default), plus pick and write.
// Init: one map word written per cycle. Free: read-modify-write (read state, then write state).
// One request at a time; the response is held until taken, then the next request is accepted.
// Reset runs the init sweep with the reset register values; no request accepted.
module page_bitmap_allocator_core
   import pba_pkg::*;
#(
   parameter int PAGE_TOTAL      = PAGE_TOTAL_DEFAULT,
   parameter int PAGE_BYTES_LOG2 = PAGE_BYTES_LOG2_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [FREE_ADDR_W-1:0] req_free_address,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [PAGE_ADDR_W-1:0] rsp_page_address,
   // configuration writes
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int WORDS   = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PAGE_W  = $clog2(PAGE_TOTAL);
   localparam int CMP_W   = ((PAGE_W + 1 > 15) ? PAGE_W + 1 : 15) + 1;
   localparam int PIDX_W  = WORD_W + BIT_W;
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_PICK,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESP
   } state_type;

   // Bits j of a map word at page base where base + j >= bound
   function automatic logic [WORD_BITS-1:0] ge_mask(input logic [CMP_W-1:0] bound,
                                                    input logic [CMP_W-1:0] base);
      logic [CMP_W-1:0] off;
      off = (bound > base) ? (bound - base) : '0;
      if (off >= CMP_W'(WORD_BITS)) begin
         return '0;
      end
      return {WORD_BITS{1'b1}} << off[BIT_W-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic                   boot_ff, boot_in;
   logic [FIRST_W-1:0]     first_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [WORD_W-1:0]      fill_ff, fill_in;
   logic [WORD_W-1:0]      scan_ff, scan_in;
   logic [WORD_W-1:0]      chk_ff, chk_in;
   logic                   pend_ff, pend_in;
   logic [WORD_BITS-1:0]   hit_word_ff, hit_word_in;
   logic [WORD_W-1:0]      free_word_ff, free_word_in;
   logic [BIT_W-1:0]       free_bit_ff, free_bit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [PAGE_ADDR_W-1:0] rsp_page_address_ff, rsp_page_address_in;

   logic                   ram_we;
   logic [WORD_W-1:0]      ram_waddr;
   logic [WORD_BITS-1:0]   ram_wdata;
   logic [WORD_W-1:0]      ram_raddr;
   logic [WORD_BITS-1:0]   ram_rdata;

   logic [WORD_BITS-1:0]   init_word;
   logic [CMP_W-1:0]       fill_base;
   logic [CMP_W-1:0]       run_end;
   logic [FREE_ADDR_W-1:0] req_page;
   logic [BIT_W-1:0]       pick_bit;
   logic [PIDX_W-1:0]      pick_page;
   logic [63:0]            pick_byte_addr;

   pba_word_ram #(
      .DEPTH  (WORDS),
      .ADDR_W (WORD_W)
   ) u_map (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   // Init word: reserved run plus any tail pages past the map end read as used
   assign fill_base = CMP_W'(fill_ff) << BIT_W;
   assign run_end   = CMP_W'(first_ff) + CMP_W'(count_ff);
   assign init_word = (ge_mask(CMP_W'(first_ff), fill_base) & ~ge_mask(run_end, fill_base))
                    | ge_mask(CMP_W'(PAGE_TOTAL), fill_base);

   // Free address to page index
   assign req_page = req_free_address >> PAGE_BYTES_LOG2;

   // Lowest free page in the hit word and its byte address
   assign pick_bit       = lowest_zero(hit_word_ff);
   assign pick_page      = {chk_ff, pick_bit};
   assign pick_byte_addr = 64'(pick_page) << PAGE_BYTES_LOG2;

   // Sequencer next state
   always_comb begin
      state_in            = state_ff;
      boot_in             = boot_ff;
      fill_in             = fill_ff;
      scan_in             = scan_ff;
      chk_in              = chk_ff;
      pend_in             = pend_ff;
      hit_word_in         = hit_word_ff;
      free_word_in        = free_word_ff;
      free_bit_in         = free_bit_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_page_address_in = rsp_page_address_ff;
      ram_we              = 1'b0;
      ram_waddr           = fill_ff;
      ram_wdata           = init_word;
      ram_raddr           = scan_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rsp_status_in       = STATUS_DONE;
               rsp_page_address_in = '0;
               case (req_opcode)
                  OP_INIT: begin
                     fill_in  = '0;
                     boot_in  = 1'b0;
                     state_in = ST_FILL;
                  end
                  OP_ALLOC: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_FREE: begin
                     if (req_page < FREE_ADDR_W'(PAGE_TOTAL)) begin
                        free_word_in = req_page[BIT_W +: WORD_W];
                        free_bit_in  = req_page[BIT_W-1:0];
                        state_in     = ST_FREE_RD;
                     end else begin
                        rsp_status_in = STATUS_OUT_OF_MAP;
                        rsp_valid_in  = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_RESP;
                  end
               endcase
            end
         end

         // one map word per cycle
         ST_FILL: begin
            ram_we  = 1'b1;
            fill_in = fill_ff + WORD_W'(1);
            if (fill_ff == LAST_WORD) begin
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_RESP;
               end
            end
         end

         // pipelined scan: issue next read, check the word read last cycle
         ST_SCAN: begin
            ram_raddr = scan_ff;
            scan_in   = scan_ff + WORD_W'(1);
            chk_in    = scan_ff;
            pend_in   = 1'b1;
            if (pend_ff) begin
               if (~&ram_rdata) begin
                  hit_word_in = ram_rdata;
                  chk_in      = chk_ff;
                  state_in    = ST_PICK;
               end else if (chk_ff == LAST_WORD) begin
                  rsp_status_in = STATUS_NO_FREE;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_RESP;
               end
            end
         end

         // mark the lowest free page used
         ST_PICK: begin
            ram_we              = 1'b1;
            ram_waddr           = chk_ff;
            ram_wdata           = hit_word_ff | (WORD_BITS'(1) << pick_bit);
            rsp_page_address_in = pick_byte_addr[PAGE_ADDR_W-1:0];
            rsp_valid_in        = 1'b1;
            state_in            = ST_RESP;
         end

         ST_FREE_RD: begin
            ram_raddr = free_word_ff;
            state_in  = ST_FREE_WR;
         end

         ST_FREE_WR: begin
            ram_we       = 1'b1;
            ram_waddr    = free_word_ff;
            ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << free_bit_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, registered outputs and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         boot_ff      <= 1'b1;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= FIRST_RESET;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RESERVED_FIRST: first_ff <= csr_data[FIRST_W-1:0];
               CSR_RESERVED_COUNT: count_ff <= csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      // data registers, no reset needed
      scan_ff             <= scan_in;
      chk_ff              <= chk_in;
      hit_word_ff         <= hit_word_in;
      free_word_ff        <= free_word_in;
      free_bit_ff         <= free_bit_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_page_address_ff <= rsp_page_address_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_page_address_ff;

endmodule

// ===== dv/page_bitmap_allocator_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the page bitmap allocator core: shadow map, mixed requests.
module page_bitmap_allocator_core_tb
   import pba_pkg::*;
();

   localparam int PAGES       = PAGE_TOTAL_DEFAULT;
   localparam int PAGE_SHIFT  = PAGE_BYTES_LOG2_DEFAULT;
   localparam int MAP_WORDS   = PAGES / WORD_BITS;
   localparam int DRAIN_TAIL  = MAP_WORDS + 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HISTORY_MAX = 64;

   // Codes the block treats as no-ops
   localparam logic [OPCODE_W-1:0]    OP_UNUSED       = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [PAGE_ADDR_W-1:0] page_address;
   } page_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [FREE_ADDR_W-1:0] req_free_address;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [PAGE_ADDR_W-1:0] rsp_page_address;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Shadow copy of the allocator state
   bit                     page_used [PAGES];
   logic [FIRST_W-1:0]     shadow_first_page;
   logic [COUNT_W-1:0]     shadow_page_count;
   page_result_type        pending_page_results [$];
   int unsigned            granted_pages [$];

   int                     send_idle_pct;
   int                     rsp_stall_pct;
   int                     error_count;
   int                     cycle_count;

   page_bitmap_allocator_core #(
      .PAGE_TOTAL      (PAGES),
      .PAGE_BYTES_LOG2 (PAGE_SHIFT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Clear the shadow map, then mark the reserved run (clipped at the map end)
   function automatic void rebuild_map();
      int unsigned stop;
      stop = int'(shadow_first_page) + int'(shadow_page_count);
      if (stop > PAGES) stop = PAGES;
      foreach (page_used[i]) page_used[i] = 1'b0;
      for (int unsigned p = shadow_first_page; p < stop; p++) page_used[p] = 1'b1;
   endfunction

   function automatic void shadow_write_reg(input logic [CSR_INDEX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_RESERVED_FIRST: shadow_first_page = data[FIRST_W-1:0];
         CSR_RESERVED_COUNT: shadow_page_count = data[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   // Apply one request to the shadow map and return the response it should give
   function automatic page_result_type shadow_map_step(input logic [OPCODE_W-1:0] op,
                                                       input logic [FREE_ADDR_W-1:0] addr);
      page_result_type res;
      logic [FREE_ADDR_W-1:0] page;
      bit found;
      res.status       = STATUS_DONE;
      res.page_address = '0;
      found            = 1'b0;
      case (op)
         OP_INIT: rebuild_map();
         OP_ALLOC: begin
            for (int i = 0; i < PAGES && !found; i++) begin
               if (!page_used[i]) begin
                  page_used[i]     = 1'b1;
                  res.page_address = PAGE_ADDR_W'(i << PAGE_SHIFT);
                  found            = 1'b1;
                  granted_pages.push_back(i);
                  if (granted_pages.size() > HISTORY_MAX) void'(granted_pages.pop_front());
               end
            end
            if (!found) res.status = STATUS_NO_FREE;
         end
         OP_FREE: begin
            page = addr >> PAGE_SHIFT;
            if (page < PAGES) page_used[page] = 1'b0;
            else res.status = STATUS_OUT_OF_MAP;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Response check, then prediction of the newly accepted request
   always @(posedge clock) begin
      page_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_page_results.size() == 0) begin
               $display("%0t: unexpected response: status %0d, page_address 0x%0h",
                        $time, rsp_status, rsp_page_address);
               error_count++;
            end else begin
               want = pending_page_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
               if (rsp_page_address !== want.page_address) begin
                  $display("%0t: page_address mismatch: expected 0x%0h, actual 0x%0h",
                           $time, want.page_address, rsp_page_address);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_page_results.push_back(shadow_map_step(req_opcode, req_free_address));
         if (csr_write_enable) shadow_write_reg(csr_index, csr_data);
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding",
                  $time, pending_page_results.size());
         $display("page_bitmap_allocator_core_tb: errors");
         $finish;
      end
   end

   // Send one request; called and returns just after a falling edge, valid left high
   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [FREE_ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid        <= 1'b0;
         req_opcode       <= OPCODE_W'($urandom);
         req_free_address <= $urandom;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_free_address <= addr;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold off requests until every response is back, then let the block settle
   task automatic wait_for_drain(input int settle);
      req_valid <= 1'b0;
      while (pending_page_results.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Write both reserved-run registers plus one write to an unmapped index, then init
   task automatic program_reserved_run(input logic [CSR_DATA_W-1:0] first_val,
                                       input logic [CSR_DATA_W-1:0] count_val);
      wait_for_drain(8);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_RESERVED_FIRST;
      csr_data         <= first_val;
      @(negedge clock);
      csr_index <= CSR_RESERVED_COUNT;
      csr_data  <= count_val;
      @(negedge clock);
      csr_index <= $urandom_range(1) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO;
      csr_data  <= CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      send_request(OP_INIT, $urandom);
   endtask

   // Map as left by reset: low pages free, reserved run above
   task automatic test_reset_map();
      send_request(OP_ALLOC, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'h0000_0000);
      send_request(OP_FREE, 32'h0000_0FFF);
      send_request(OP_ALLOC, $urandom);
      send_request(OP_FREE, 32'hFFFF_FFFF);
      send_request(OP_FREE, 32'h0200_0000);
      send_request(OP_FREE, 32'h01FF_FFFF);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
   endtask

   // Full map, clipped run, empty run; freeing a free page
   task automatic test_reserved_run_extremes();
      program_reserved_run(CSR_DATA_W'(PAGES), CSR_DATA_W'(PAGES) & '0 | CSR_DATA_W'(PAGES));
      wait_for_drain(8);
      program_reserved_run('0, CSR_DATA_W'(PAGES));
      send_request(OP_ALLOC, $urandom);
      send_request(OP_FREE, 32'h01FF_F000);
      send_request(OP_FREE, 32'h01FF_F123);
      send_request(OP_ALLOC, $urandom);
      send_request(OP_ALLOC, $urandom);
      // first page has bit 13 set in the write data: dropped by the 13-bit register
      program_reserved_run('1, '1);
      send_request(OP_ALLOC, $urandom);
      program_reserved_run('0, '0);
      send_request(OP_ALLOC, $urandom);
   endtask

   // Random traffic over three reserved-run settings
   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int items);
      int unsigned first_val;
      int unsigned count_val;
      int unsigned pick;
      logic [FREE_ADDR_W-1:0] addr;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int seg = 0; seg < 3; seg++) begin
         case ($urandom_range(3))
            0: begin
               // nearly full: a few free pages at each end
               first_val = $urandom_range(0, 12);
               count_val = PAGES - first_val - $urandom_range(0, 12);
            end
            1: begin
               first_val = 0;
               count_val = PAGES;
            end
            2: begin
               first_val = $urandom_range(0, PAGES - 1);
               count_val = $urandom_range(0, PAGES);
            end
            default: begin
               // run near the top, often clipped
               first_val = $urandom_range(PAGES - 92, PAGES - 1);
               count_val = $urandom_range(0, (1 << COUNT_W) - 1);
            end
         endcase
         program_reserved_run(CSR_DATA_W'(first_val), CSR_DATA_W'(count_val));
         for (int k = 0; k < items / 3; k++) begin
            pick = $urandom_range(99);
            addr = $urandom;
            if (pick < 4) begin
               send_request(OP_INIT, addr);
            end else if (pick < 7) begin
               send_request(OP_UNUSED, addr);
            end else if (pick < 62) begin
               send_request(OP_ALLOC, addr);
            end else begin
               pick = $urandom_range(99);
               if (pick < 55 && granted_pages.size() > 0)
                  addr = (FREE_ADDR_W'(granted_pages[$urandom_range(granted_pages.size() - 1)])
                          << PAGE_SHIFT) | FREE_ADDR_W'($urandom_range((1 << PAGE_SHIFT) - 1));
               else if (pick < 85)
                  addr = FREE_ADDR_W'($urandom_range(0, (PAGES << PAGE_SHIFT) - 1));
               else
                  addr = {7'($urandom_range(1, 127)), 25'($urandom)};
               send_request(OP_FREE, addr);
            end
            // pause until the pipeline is empty once per phase
            if (seg == 1 && k == items / 6) wait_for_drain(1);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_INIT;
      req_free_address = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_RESERVED_FIRST;
      csr_data         = '0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      error_count      = 0;
      cycle_count      = 0;
      shadow_first_page = FIRST_RESET;
      shadow_page_count = COUNT_RESET;
      rebuild_map();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_map();
      test_reserved_run_extremes();
      test_random_traffic(0, 0, 225);
      test_random_traffic(79, 0, 225);
      test_random_traffic(0, 79, 225);
      test_random_traffic(38, 38, 225);

      wait_for_drain(DRAIN_TAIL);
      if (pending_page_results.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_page_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("page_bitmap_allocator_core_tb: clean");
      else
         $display("page_bitmap_allocator_core_tb: errors");
      $finish;
   end

endmodule
